@@ sv/esu_pkg.sv @@
package esu_pkg;

  localparam int MaxPatBytes = 8;
  localparam int MaxRepBytes = 8;
  localparam int CntW        = 4;  // holds 0..8 result bytes
  localparam int IdxW        = 3;  // indexes one of eight bytes

  typedef enum logic [2:0] {
    CfgPattern = 3'd0,
    CfgPatLen  = 3'd1,
    CfgRepl    = 3'd2,
    CfgRepLen  = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  // configuration as seen by the datapath, lengths already saturated
  typedef struct packed {
    logic [63:0]     pat;
    logic [CntW-1:0] plen;
    logic [63:0]     rep;
    logic [CntW-1:0] rlen;
  } cfg_t;

  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic load;    // output register takes the next result
  } cmd_t;

  typedef struct packed {
    logic silent;      // item produced no result at all
    logic final_elem;  // result at the current index is the last of the item
  } stat_t;

endpackage

@@ sv/esu_cfg.sv @@
module esu_cfg import esu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o,
  output logic        clr_o
);

  logic [63:0]     pat_q, pat_d;
  logic [CntW-1:0] plen_q, plen_d;
  logic [63:0]     rep_q, rep_d;
  logic [CntW-1:0] rlen_q, rlen_d;
  logic            clr;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pat_d  = pat_q;
    plen_d = plen_q;
    rep_d  = rep_q;
    rlen_d = rlen_q;
    clr    = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPattern: begin
          pat_d = cfg_data_i;
          clr   = 1'b1;
        end
        CfgPatLen: begin
          plen_d = cfg_data_i[CntW-1:0];
          clr    = 1'b1;
        end
        CfgRepl: begin
          rep_d = cfg_data_i;
        end
        CfgRepLen: begin
          rlen_d = cfg_data_i[CntW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= 64'd92;
      plen_q <= CntW'(1);
      rep_q  <= 64'd23644;
      rlen_q <= CntW'(2);
    end else begin
      pat_q  <= pat_d;
      plen_q <= plen_d;
      rep_q  <= rep_d;
      rlen_q <= rlen_d;
    end
  end

  assign clr_o = clr;

  // empty pattern counts as one byte, lengths saturate at the buffer size
  always_comb begin
    cfg_o.pat = pat_q;
    cfg_o.rep = rep_q;
    if (plen_q == '0) begin
      cfg_o.plen = CntW'(1);
    end else if (plen_q > CntW'(MaxPatBytes)) begin
      cfg_o.plen = CntW'(MaxPatBytes);
    end else begin
      cfg_o.plen = plen_q;
    end
    if (rlen_q > CntW'(MaxRepBytes)) begin
      cfg_o.rlen = CntW'(MaxRepBytes);
    end else begin
      cfg_o.rlen = rlen_q;
    end
  end

endmodule

@@ sv/esu_dp.sv @@
module esu_dp import esu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       clr_i,
  input  cmd_t       cmd_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output stat_t      stat_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  function automatic logic [7:0] byte_at(logic [63:0] word, logic [IdxW-1:0] idx);
    byte_at = word[{idx, 3'b000} +: 8];
  endfunction

  // matched prefix length, always below the pattern length
  logic [IdxW-1:0] m_q, m_d;

  // item under emission
  logic [IdxW-1:0] held_q;
  logic [7:0]      b_q;
  logic            last_q;
  logic            hit_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;

  // output register
  logic [7:0]      obyte_q;
  logic            bvalid_q;
  logic            rlast_q;
  logic            send_q;

  logic [CntW-1:0] m_new;
  logic            cand;
  logic [CntW-1:0] base;
  logic [IdxW-1:0] pi;
  logic            hit;
  logic [CntW-1:0] held_p1;
  logic [CntW-1:0] cnt;
  logic [7:0]      sel_byte;
  logic            final_elem;

  // longest pattern prefix that ends the held prefix followed by the new byte
  always_comb begin
    m_new = '0;
    base  = '0;
    pi    = '0;
    cand  = 1'b0;
    for (int k = 1; k <= MaxPatBytes; k++) begin
      cand = (int'(m_q) + 1 >= k) &&
             (byte_at(cfg_i.pat, IdxW'(k - 1)) == in_byte_i);
      base = CntW'(int'(m_q) + 1 - k);
      for (int i = 0; i < k - 1; i++) begin
        pi   = IdxW'(base + CntW'(i));
        cand = cand && (byte_at(cfg_i.pat, IdxW'(i)) == byte_at(cfg_i.pat, pi));
      end
      if (cand) begin
        m_new = CntW'(k);
      end
    end
  end

  assign held_p1 = {1'b0, m_q} + CntW'(1);
  assign hit     = (m_new == cfg_i.plen);

  // on a miss the held prefix plus the new byte is the only byte source;
  // at end of string all of it goes out
  always_comb begin
    if (hit) begin
      cnt = cfg_i.rlen;
    end else if (in_last_i) begin
      cnt = held_p1;
    end else begin
      cnt = held_p1 - m_new;
    end
  end

  always_comb begin
    m_d = m_q;
    if (clr_i) begin
      m_d = '0;
    end else if (cmd_i.accept) begin
      m_d = (hit || in_last_i) ? '0 : m_new[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else begin
      m_q <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      held_q  <= m_q;
      b_q     <= in_byte_i;
      last_q  <= in_last_i;
      hit_q   <= hit;
      count_q <= cnt;
      idx_q   <= '0;
    end else if (cmd_i.load) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_comb begin
    if (hit_q) begin
      sel_byte = byte_at(cfg_i.rep, idx_q);
    end else if (idx_q < held_q) begin
      sel_byte = byte_at(cfg_i.pat, idx_q);
    end else begin
      sel_byte = b_q;
    end
  end

  assign final_elem = (count_q == '0) || ({1'b0, idx_q} == count_q - CntW'(1));

  assign stat_o.silent     = (count_q == '0) && !last_q;
  assign stat_o.final_elem = final_elem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      obyte_q  <= (count_q == '0) ? 8'd0 : sel_byte;
      bvalid_q <= (count_q != '0);
      rlast_q  <= final_elem;
      send_q   <= final_elem && last_q;
    end
  end

  assign out_byte_o   = obyte_q;
  assign byte_valid_o = bvalid_q;
  assign run_last_o   = rlast_q;
  assign string_end_o = send_q;

endmodule

@@ sv/esu_ctrl.sv @@
module esu_ctrl import esu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load;

  assign accept = (state_q == StIdle) && in_valid_i;
  assign load   = (state_q == StEmit) && !stat_i.silent &&
                  (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.silent || (load && stat_i.final_elem)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load)
    else $error("output register overwritten while stalled");

  // an input transfer always starts emission
  a_accept_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StEmit))
    else $error("accepted item not emitted");

  // the last result of an item returns the unit to idle
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && stat_i.final_elem) |=> (state_q == StIdle && out_valid_q))
    else $error("item did not finish after its last result");

  // output data only appears after an item was taken
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StEmit))
    else $error("result without an item in emission");

endmodule

@@ sv/escape_sequence_substituter_unit.sv @@
// an accepted item is held in the item registers; each of its results then goes through the output register
// the unit takes no new item until it is through with the last one, which is emitted by
//   the emit sequencer that sends one result byte per cycle while the output is not stalled
// output stalls extend emission; the output register frees the input side at the end
// reset: matched prefix cleared, pattern 0x5c, length 1, replacement 0x5c5c, length 2
module escape_sequence_substituter_unit import esu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        string_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t  cfg;
  logic  clr;
  cmd_t  cmd;
  stat_t stat;

  esu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clr_o       (clr)
  );

  esu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  esu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clr_i        (clr),
    .cmd_i        (cmd),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .stat_o       (stat),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule
